/* hdl/dftm_pkg.sv */
// Shared constants, types and elaboration-time functions for the direct DFT magnitude unit.
// Holds the field widths, the Q1.15 cosine/sine table builder and the saturation limit.
// No dependencies.
package dftm_pkg;

  // Defaults for the top-level parameters
  localparam int POINTS_DEF      = 500;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int MAX_POINTS      = 1024;

  // Word field widths
  localparam int POS_W      = 9;
  localparam int SMP_W      = 12;
  localparam int BIN_W      = 9;
  localparam int PART_W     = 22;
  localparam int MAG_W      = 21;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 80;

  // Arithmetic widths
  localparam int ROM_W     = 16;
  localparam int FRAC_BITS = 15;
  localparam int MUL_W     = 2 * PART_W;
  localparam int SQ_W      = 2 * PART_W - 1;
  localparam int SQRT_TOP  = SQ_W - 1;
  localparam int ROOT_W    = PART_W;

  // Input kinds carried on tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ROM_MAX     = 32767;
  localparam longint          FIELD_MAX   = 2097151;

  // One table word: sine in the upper half, cosine in the lower half
  typedef logic [2*ROM_W-1:0] trig_word_t;
  typedef trig_word_t trig_table_t [MAX_POINTS];

  // Unsigned shift-subtract division, used only while building constants
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = 0;
    quo = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q30 magnitude to a signed Q1.15 word, rounded half up and clamped
  function automatic logic [ROM_W-1:0] to_q15(input longint mag, input logic neg);
    longint v;
    v = (mag * 32768 + (longint'(1) << 29)) >>> 30;
    if (v > ROM_MAX) v = ROM_MAX;
    if (neg) v = -v;
    return v[ROM_W-1:0];
  endfunction

  // Build the cosine/sine table by quadrant reduction and a Q30 Taylor series
  function automatic trig_table_t trig_table(input int points);
    trig_table_t     tbl;
    longint unsigned pts;
    longint unsigned p;
    longint unsigned q;
    longint unsigned r;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned ts;
    longint unsigned tc;
    longint unsigned ii;
    longint          s;
    longint          c;
    logic [ROM_W-1:0] cw;
    logic [ROM_W-1:0] sw;
    pts = longint'(points);
    for (int m = 0; m < MAX_POINTS; m++) begin
      tbl[m] = '0;
      if (m < points) begin
        p  = 4 * longint'(m);
        q  = udiv(p, pts);
        r  = p - q * pts;
        a  = udiv(HALF_PI_Q30 * r, pts);
        a2 = (a * a) >> 30;
        ts = a;
        tc = Q30_ONE;
        s  = longint'(a);
        c  = longint'(Q30_ONE);
        for (int i = 1; i <= 10; i++) begin
          ii = longint'(i);
          ts = udiv((ts * a2) >> 30, (2 * ii) * (2 * ii + 1));
          tc = udiv((tc * a2) >> 30, (2 * ii - 1) * (2 * ii));
          if (i % 2 == 1) begin
            s = s - longint'(ts);
            c = c - longint'(tc);
          end else begin
            s = s + longint'(ts);
            c = c + longint'(tc);
          end
        end
        if (s < 0) s = 0;
        if (s > longint'(Q30_ONE)) s = longint'(Q30_ONE);
        if (c < 0) c = 0;
        if (c > longint'(Q30_ONE)) c = longint'(Q30_ONE);
        case (q[1:0])
          2'd0: begin
            cw = to_q15(c, 1'b0);
            sw = to_q15(s, 1'b0);
          end
          2'd1: begin
            cw = to_q15(s, 1'b1);
            sw = to_q15(c, 1'b0);
          end
          2'd2: begin
            cw = to_q15(c, 1'b1);
            sw = to_q15(s, 1'b1);
          end
          default: begin
            cw = to_q15(s, 1'b0);
            sw = to_q15(c, 1'b1);
          end
        endcase
        tbl[m] = {sw, cw};
      end
    end
    return tbl;
  endfunction

  // Saturation limit of the real, imaginary and magnitude fields
  function automatic logic [MAG_W-1:0] part_limit(input int points, input int sample_bits);
    longint lim;
    lim = ((longint'(1) << sample_bits) - 1) * longint'(points);
    if (lim > FIELD_MAX) lim = FIELD_MAX;
    return lim[MAG_W-1:0];
  endfunction

endpackage

/* hdl/dftm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dftm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 500
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/dftm_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
// Depends on dftm_pkg for the operand and root widths.
module dftm_isqrt
  import dftm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic            busy;
  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] weight;
  logic [SQ_W:0]   trial;

  // Candidate to subtract at this step
  assign trial = {1'b0, res} + {1'b0, weight};

  // Control: busy while weight walks down two bits a step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && weight[0];
      if (start) begin
        busy <= 1'b1;
      end else if (busy && weight[0]) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: restoring digit-by-digit root
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= value;
      res    <= '0;
      weight <= SQ_W'(1) << SQRT_TOP;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + weight;
      end else begin
        res <= res >> 1;
      end
      weight <= weight >> 2;
    end
  end

  assign root = res[ROOT_W-1:0];

endmodule

/* hdl/direct_dft_magnitude_unit.sv */
// Direct real-input DFT bin unit: loads samples and returns one bin with magnitude per query.
// Load: no result. Query: steps reduce (POINTS taken off a larger bin per step), a MAC per
// sample, drain, scale, square, sum, root and out; not ready meanwhile, and a waiting result
// word holds the last step. rst is synchronous, active high, control only.
// Depends on dftm_pkg, dftm_ram and dftm_isqrt.
module direct_dft_magnitude_unit
  import dftm_pkg::*;
#(
  parameter int POINTS      = POINTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // position[8:0], sample[20:9], zero pad
  input  logic [0:0]            s_axis_tuser,  // mode[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // bin[8:0], real_part[30:9],
                                               // imag_part[52:31], magnitude[73:53], zero pad
);

  localparam int IDX_W      = $clog2(POINTS);
  localparam int TRIG_IDX_W = $clog2(MAX_POINTS);
  localparam int KW         = (POS_W > IDX_W + 1) ? POS_W : IDX_W + 1;
  localparam int ACC_W      = SAMPLE_BITS + ROM_W + IDX_W + 1;

  localparam logic [MAG_W-1:0]        LIMIT   = part_limit(POINTS, SAMPLE_BITS);
  localparam logic signed [ACC_W-1:0] LIM_POS = $signed(ACC_W'(LIMIT));
  localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;
  localparam trig_table_t             TRIG    = trig_table(POINTS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_REDUCE = 4'd1;
  localparam logic [3:0] ST_MAC    = 4'd2;
  localparam logic [3:0] ST_DRAIN  = 4'd3;
  localparam logic [3:0] ST_SCALE  = 4'd4;
  localparam logic [3:0] ST_SQUARE = 4'd5;
  localparam logic [3:0] ST_SUM    = 4'd6;
  localparam logic [3:0] ST_ROOT   = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state;

  // Input word fields
  logic                   in_mode;
  logic [POS_W-1:0]       in_pos;
  logic [SMP_W-1:0]       in_smp;
  logic                   in_accept;
  logic                   load_en;

  // Query sequencing
  logic [KW-1:0]          kstep;
  logic [BIN_W-1:0]       bin;
  logic [IDX_W-1:0]       n;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W:0]         idx_sum;
  logic [IDX_W-1:0]       idx_next;
  logic                   v1;
  logic                   v2;

  // Datapath
  logic [SAMPLE_BITS-1:0] x;
  trig_word_t             trig;
  logic signed [PART_W-1:0] x_ext;
  logic signed [PART_W-1:0] cos_ext;
  logic signed [PART_W-1:0] sin_ext;
  logic signed [PART_W-1:0] op_a0;
  logic signed [PART_W-1:0] op_b0;
  logic signed [PART_W-1:0] op_a1;
  logic signed [PART_W-1:0] op_b1;
  logic signed [MUL_W-1:0]  prod0;
  logic signed [MUL_W-1:0]  prod1;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;
  logic signed [PART_W-1:0] re;
  logic signed [PART_W-1:0] im;
  logic [SQ_W-1:0]          sq_sum;
  logic                     sqrt_start;
  logic                     sqrt_done;
  logic [ROOT_W-1:0]        root;
  logic [MAG_W-1:0]         mag;
  logic                     sq_phase;

  // Floor-shift by the fraction bits and clamp to the field limit
  function automatic logic signed [PART_W-1:0] scale_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sh;
    logic signed [PART_W-1:0] v;
    sh = a >>> FRAC_BITS;
    if (sh > LIM_POS) begin
      v = PART_W'(LIM_POS);
    end else if (sh < LIM_NEG) begin
      v = PART_W'(LIM_NEG);
    end else begin
      v = PART_W'(sh);
    end
    return v;
  endfunction

  // Unpack the input word
  assign in_mode   = s_axis_tuser[0];
  assign in_pos    = s_axis_tdata[POS_W-1:0];
  assign in_smp    = s_axis_tdata[POS_W+SMP_W-1:POS_W];
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign load_en   = in_accept && (in_mode == MODE_LOAD) && (KW'(in_pos) < KW'(POINTS));

  // Sample store
  dftm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (IDX_W'(in_pos)),
    .wr_data (SAMPLE_BITS'(in_smp)),
    .rd_addr (n),
    .rd_data (x)
  );

  // Cosine/sine table with registered read
  always_ff @(posedge clk) begin
    trig <= TRIG[TRIG_IDX_W'(idx)];
  end

  // Advance the table index by k modulo POINTS
  assign idx_sum  = {1'b0, idx} + (IDX_W+1)'(kstep);
  assign idx_next = (idx_sum >= (IDX_W+1)'(POINTS)) ? IDX_W'(idx_sum - (IDX_W+1)'(POINTS))
                                                   : IDX_W'(idx_sum);

  // Shared multiplier pair: MAC products, then the two squares
  assign sq_phase = (state == ST_SQUARE);
  assign x_ext    = $signed(PART_W'(x));
  assign cos_ext  = PART_W'($signed(trig[ROM_W-1:0]));
  assign sin_ext  = PART_W'($signed(trig[2*ROM_W-1:ROM_W]));
  assign op_a0    = sq_phase ? re : x_ext;
  assign op_b0    = sq_phase ? re : cos_ext;
  assign op_a1    = sq_phase ? im : x_ext;
  assign op_b1    = sq_phase ? im : sin_ext;

  always_ff @(posedge clk) begin
    prod0 <= op_a0 * op_b0;
    prod1 <= op_a1 * op_b1;
  end

  // Sum of squares for the root unit
  assign sq_sum     = {1'b0, prod0[SQ_W-2:0]} + {1'b0, prod1[SQ_W-2:0]};
  assign sqrt_start = (state == ST_SUM);

  dftm_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sq_sum),
    .done  (sqrt_done),
    .root  (root)
  );

  // Pipeline valid bits behind the store and table reads
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_MAC);
      v2 <= v1;
    end
  end

  // Accumulate, scale and hold the bin payload
  always_ff @(posedge clk) begin
    if (in_accept && in_mode == MODE_QUERY) begin
      acc_re <= '0;
      acc_im <= '0;
      bin    <= in_pos;
    end else if (v2) begin
      acc_re <= acc_re + ACC_W'(prod0);
      acc_im <= acc_im - ACC_W'(prod1);
    end
    if (state == ST_SCALE) begin
      re <= scale_sat(acc_re);
      im <= scale_sat(acc_im);
    end
    if (state == ST_ROOT && sqrt_done) begin
      mag <= (root > ROOT_W'(LIMIT)) ? LIMIT : root[MAG_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      n             <= '0;
      idx           <= '0;
      kstep         <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept && in_mode == MODE_QUERY) begin
            kstep <= KW'(in_pos);
            n     <= '0;
            idx   <= '0;
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (kstep >= KW'(POINTS)) begin
            kstep <= kstep - KW'(POINTS);
          end else begin
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          n   <= n + 1'b1;
          idx <= idx_next;
          if (n == IDX_W'(POINTS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE:  state <= ST_SQUARE;
        ST_SQUARE: state <= ST_SUM;
        ST_SUM:    state <= ST_ROOT;
        ST_ROOT: begin
          if (sqrt_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {(OUT_DATA_W - BIN_W - 2*PART_W - MAG_W)'(0), mag, im, re, bin};
    end
  end

endmodule
